>>> design/ttip_pkg.sv
`default_nettype none

package ttip_pkg;

    // one character of the text stream
    typedef struct packed {
        logic [7:0] char_in;
        logic       begin_req;
    } item_t;

    // one finished conversion
    typedef struct packed {
        logic signed [31:0] value;
        logic [15:0]        consumed_count;
        logic               overflowed;
        logic               digits_found;
    } res_t;

    typedef enum logic [5:0] {
        PH_SPACE  = 6'b000001,
        PH_SIGN   = 6'b000010,
        PH_ZERO   = 6'b000100,
        PH_HEX    = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    localparam logic [5:0] RADIX_AUTO  = 6'd0;
    localparam logic [5:0] RADIX_OCT   = 6'd8;
    localparam logic [5:0] RADIX_DEC   = 6'd10;
    localparam logic [5:0] RADIX_HEX   = 6'd16;
    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    // no radix reaches this, so a non-digit never passes the digit < radix test
    localparam logic [5:0] DIGIT_NONE  = 6'd63;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            d = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UZ) begin
            d = c - CH_UA + 8'd10;
        end else begin
            d = {2'b00, DIGIT_NONE};
        end
        return d[5:0];
    endfunction

endpackage

`default_nettype wire

>>> design/ttip_text_if.sv
`default_nettype none

interface ttip_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       begin_req;

    modport source (output valid, output char_in, output begin_req, input ready);
    modport sink (input valid, input char_in, input begin_req, output ready);
endinterface

`default_nettype wire

>>> design/ttip_result_if.sv
`default_nettype none

interface ttip_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value;
    logic [15:0]        consumed_count;
    logic               overflowed;
    logic               digits_found;

    modport source (output valid, output value, output consumed_count,
                    output overflowed, output digits_found, input ready);
    modport sink (input valid, input value, input consumed_count,
                  input overflowed, input digits_found, output ready);
endinterface

`default_nettype wire

>>> design/ttip_cfg_if.sv
`default_nettype none

interface ttip_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] radix_select;

    modport source (output valid, output radix_select, input ready);
    modport sink (input valid, input radix_select, output ready);
endinterface

`default_nettype wire

>>> design/ttip_in_stage.sv
`default_nettype none

module ttip_in_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire ttip_pkg::item_t in_item,
    input  wire logic           step_go,
    output logic                item_valid,
    output ttip_pkg::item_t     item
);

    logic            valid_reg;
    logic            valid_next;
    ttip_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || step_go;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (step_go ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> design/ttip_step.sv
`default_nettype none

module ttip_step #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step_go,
    input  wire ttip_pkg::item_t item,
    input  wire logic [5:0]      radix_select,
    output logic                 emit,
    output ttip_pkg::res_t       res
);

    localparam int PW = VALUE_BITS + 6;
    localparam int OW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    ttip_pkg::phase_t        phase_reg, phase_next;
    logic [VALUE_BITS-1:0]   mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic                    ovf_reg, ovf_next;
    logic                    anyd_reg, anyd_next;
    logic [5:0]              wr_reg, wr_next;
    logic [COUNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [COUNT_BITS-1:0]   endc_reg, endc_next;

    logic                    try_zero;
    logic                    run_digit;
    logic [5:0]              digit;
    logic [VALUE_BITS-1:0]   lim;
    logic [PW-1:0]           prod;
    logic [VALUE_BITS-1:0]   mag_out;
    logic [OW-1:0]           mag_ext;
    logic [OW-1:0]           signed_ext;
    logic [CW-1:0]           endc_ext;

    function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + COUNT_BITS'(1);
    endfunction

    always_comb
    begin
        if (item.begin_req)
        begin
            phase_next = ttip_pkg::PH_SPACE;
            mag_next   = '0;
            neg_next   = 1'b0;
            ovf_next   = 1'b0;
            anyd_next  = 1'b0;
            wr_next    = ttip_pkg::RADIX_AUTO;
            cnt_next   = '0;
            endc_next  = '0;
        end
        else
        begin
            phase_next = phase_reg;
            mag_next   = mag_reg;
            neg_next   = neg_reg;
            ovf_next   = ovf_reg;
            anyd_next  = anyd_reg;
            wr_next    = wr_reg;
            cnt_next   = cnt_reg;
            endc_next  = endc_reg;
        end

        try_zero  = 1'b0;
        run_digit = 1'b0;
        emit      = 1'b0;
        digit     = ttip_pkg::digit_of(item.char_in);
        lim       = '0;
        prod      = '0;

        case (phase_next)
            ttip_pkg::PH_SPACE:
            begin
                if (ttip_pkg::is_space(item.char_in))
                begin
                    cnt_next = bump(cnt_next);
                end
                else
                begin
                    wr_next = radix_select;
                    if (item.char_in == ttip_pkg::CH_MINUS || item.char_in == ttip_pkg::CH_PLUS)
                    begin
                        neg_next   = (item.char_in == ttip_pkg::CH_MINUS);
                        cnt_next   = bump(cnt_next);
                        phase_next = ttip_pkg::PH_SIGN;
                    end
                    else
                    begin
                        try_zero = 1'b1;
                    end
                end
            end
            ttip_pkg::PH_SIGN:
            begin
                try_zero = 1'b1;
            end
            ttip_pkg::PH_ZERO:
            begin
                if (item.char_in == ttip_pkg::CH_LX || item.char_in == ttip_pkg::CH_UX)
                begin
                    cnt_next   = bump(cnt_next);
                    wr_next    = ttip_pkg::RADIX_HEX;
                    phase_next = ttip_pkg::PH_HEX;
                end
                else
                begin
                    // the leading zero counts as a digit of value zero
                    if (wr_next == ttip_pkg::RADIX_AUTO)
                    begin
                        wr_next = ttip_pkg::RADIX_OCT;
                    end
                    anyd_next = 1'b1;
                    endc_next = cnt_next;
                    run_digit = 1'b1;
                end
            end
            ttip_pkg::PH_HEX, ttip_pkg::PH_DIGITS:
            begin
                run_digit = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (try_zero)
        begin
            if ((wr_next == ttip_pkg::RADIX_AUTO || wr_next == ttip_pkg::RADIX_HEX)
                && item.char_in == ttip_pkg::CH_0)
            begin
                cnt_next   = bump(cnt_next);
                phase_next = ttip_pkg::PH_ZERO;
            end
            else
            begin
                if (wr_next == ttip_pkg::RADIX_AUTO)
                begin
                    wr_next = ttip_pkg::RADIX_DEC;
                end
                run_digit = 1'b1;
            end
        end

        lim  = {1'b0, {(VALUE_BITS-1){1'b1}}} + VALUE_BITS'(neg_next);
        prod = PW'(mag_next) * PW'(wr_next) + PW'(digit);

        if (run_digit)
        begin
            if (wr_next inside {[ttip_pkg::RADIX_MIN:ttip_pkg::RADIX_MAX]} && digit < wr_next)
            begin
                cnt_next = bump(cnt_next);
                if (ovf_next || prod > PW'(lim))
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    mag_next = prod[VALUE_BITS-1:0];
                end
                anyd_next  = 1'b1;
                endc_next  = cnt_next;
                phase_next = ttip_pkg::PH_DIGITS;
            end
            else
            begin
                emit       = 1'b1;
                phase_next = ttip_pkg::PH_DONE;
            end
        end
    end

    // result fields come from the state as it stands after this character
    assign mag_out    = ovf_next ? lim : mag_next;
    assign mag_ext    = OW'(mag_out);
    assign signed_ext = neg_next ? (~mag_ext + OW'(1)) : mag_ext;
    assign endc_ext   = CW'(endc_next);

    assign res.value          = signed_ext[31:0];
    assign res.consumed_count = anyd_next ? endc_ext[15:0] : 16'd0;
    assign res.overflowed     = ovf_next;
    assign res.digits_found   = anyd_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ttip_pkg::PH_SPACE;
            mag_reg   <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
            anyd_reg  <= 1'b0;
            wr_reg    <= ttip_pkg::RADIX_AUTO;
            cnt_reg   <= '0;
            endc_reg  <= '0;
        end
        else if (step_go)
        begin
            phase_reg <= phase_next;
            mag_reg   <= mag_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
            anyd_reg  <= anyd_next;
            wr_reg    <= wr_next;
            cnt_reg   <= cnt_next;
            endc_reg  <= endc_next;
        end
    end

endmodule

`default_nettype wire

>>> design/ttip_out_stage.sv
`default_nettype none

module ttip_out_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire ttip_pkg::res_t res_in,
    output logic                room,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ttip_pkg::res_t      res_out
);

    logic           valid_reg;
    logic           valid_next;
    ttip_pkg::res_t res_reg;

    // a step may run when the slot is free or being emptied this cycle
    assign room       = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

>>> design/text_to_integer_parser.sv
// Streaming text to signed integer converter, one character per transfer.
// Path: the character that ends a result is held in the input register, and the parse
// step then loads the result register, from which the result is offered.
// Throughput: 1 character per cycle while the result register has room for the step.
// Reset: rst_n clears parse state, radix (auto) and all valid flags at once.
`default_nettype none

module text_to_integer_parser #(
    parameter int VALUE_BITS = 32,
    parameter int COUNT_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ttip_cfg_if.sink      cfg,
    ttip_text_if.sink     text,
    ttip_result_if.source result
);

    logic            cfg_fire;
    logic [5:0]      radix_select_reg;
    ttip_pkg::item_t in_item;
    ttip_pkg::item_t item;
    logic            item_valid;
    logic            step_go;
    logic            room;
    logic            emit;
    ttip_pkg::res_t  step_res;
    ttip_pkg::res_t  res_out;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_select_reg <= ttip_pkg::RADIX_AUTO;
        end
        else if (cfg_fire)
        begin
            radix_select_reg <= cfg.radix_select;
        end
    end

    assign in_item.char_in   = text.char_in;
    assign in_item.begin_req = text.begin_req;
    assign step_go           = item_valid && room;

    ttip_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (text.valid),
        .in_ready   (text.ready),
        .in_item    (in_item),
        .step_go    (step_go),
        .item_valid (item_valid),
        .item       (item)
    );

    ttip_step #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_go      (step_go),
        .item         (item),
        .radix_select (radix_select_reg),
        .emit         (emit),
        .res          (step_res)
    );

    ttip_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step_go && emit),
        .res_in    (step_res),
        .room      (room),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .res_out   (res_out)
    );

    assign result.value          = res_out.value;
    assign result.consumed_count = res_out.consumed_count;
    assign result.overflowed     = res_out.overflowed;
    assign result.digits_found   = res_out.digits_found;

endmodule

`default_nettype wire
